### hdl/assert_macros.svh
// Assertion macros for the I2C byte engine RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/ibe_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies.
package ibe_pkg;

  localparam int TICK_W = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd100;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] command;
    logic [7:0] write_byte;
    logic       send_nack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_ok;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] write_byte;
    logic       send_nack;
    logic       sda_in;
  } q_entry_t;

endpackage

### hdl/ibe_front.sv
// Front end: takes input ticks and decodes the command field into an op.
// Depends on ibe_pkg.
module ibe_front (
  input  ibe_pkg::in_item_t in_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output ibe_pkg::q_entry_t q_wdata
);
  import ibe_pkg::*;

  op_t op;

  always_comb begin
    if (!in_data.cmd_valid) begin
      op = OP_NONE;
    end else begin
      unique case (in_data.command)
        CMD_START: op = OP_START;
        CMD_STOP:  op = OP_STOP;
        CMD_WRITE: op = OP_WRITE;
        CMD_READ:  op = OP_READ;
        default:   op = OP_NONE;
      endcase
    end
  end

  assign in_stall           = q_full;
  assign q_push             = in_valid && !q_full;
  assign q_wdata.op         = op;
  assign q_wdata.write_byte = in_data.write_byte;
  assign q_wdata.send_nack  = in_data.send_nack;
  assign q_wdata.sda_in     = in_data.sda_in;

endmodule

### hdl/ibe_queue.sv
// Short FIFO of decoded ticks between the front end and the sequencer.
// Depends on ibe_pkg.
module ibe_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ibe_pkg::q_entry_t wdata,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output ibe_pkg::q_entry_t rdata
);
  import ibe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_entry_t      slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/ibe_back.sv
// Back end: bus phase sequencer, one tick per popped entry, and the result register.
// Depends on ibe_pkg.
module ibe_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ibe_pkg::TICK_W-1:0]     cfg_wdata,
  input  logic                           q_valid,
  input  ibe_pkg::q_entry_t              q_rdata,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ibe_pkg::out_item_t             out_data
);
  import ibe_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START1, PH_START2, PH_START3, PH_START4,
    PH_STOP1, PH_STOP2, PH_STOP3, PH_STOP4,
    PH_WR_BIT, PH_WR_LOW, PH_WR_ACK, PH_WR_END,
    PH_RD_BIT, PH_RD_LOW, PH_RD_ACK, PH_RD_END
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [TICK_W-1:0] timer_r, timer_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ack_r, ack_nxt;
  logic              nack_r, nack_nxt;
  logic [7:0]        rd_hold_r, rd_hold_nxt;
  logic              done_nxt;
  logic [TICK_W-1:0] ticks_r;
  logic [TICK_W-1:0] reload;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              fire;

  // A zero phase length behaves as one tick.
  assign reload = (ticks_r == '0) ? '0 : ticks_r - TICK_W'(1);

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    timer_nxt   = timer_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    nack_nxt    = nack_r;
    rd_hold_nxt = rd_hold_r;
    done_nxt    = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (q_rdata.op != OP_NONE) begin
        bit_cnt_nxt = '0;
        timer_nxt   = reload;
      end
      unique case (q_rdata.op)
        OP_START: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START1;
        end
        OP_STOP: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_STOP1;
        end
        OP_WRITE: begin
          shift_nxt = q_rdata.write_byte;
          sda_nxt   = ~q_rdata.write_byte[7];
          scl_nxt   = 1'b0;
          phase_nxt = PH_WR_BIT;
        end
        OP_READ: begin
          shift_nxt = '0;
          nack_nxt  = q_rdata.send_nack;
          sda_nxt   = 1'b0;
          scl_nxt   = 1'b0;
          phase_nxt = PH_RD_BIT;
        end
        default: ;
      endcase
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - TICK_W'(1);
    end else begin
      // End of phase: sample where needed and advance.
      timer_nxt = reload;
      unique case (phase_r)
        PH_START1: begin scl_nxt = 1'b0; phase_nxt = PH_START2; end
        PH_START2: begin sda_nxt = 1'b1; phase_nxt = PH_START3; end
        PH_START3: begin scl_nxt = 1'b1; phase_nxt = PH_START4; end
        PH_STOP1:  begin scl_nxt = 1'b0; phase_nxt = PH_STOP2; end
        PH_STOP2:  begin sda_nxt = 1'b0; phase_nxt = PH_STOP3; end
        PH_STOP3:  begin scl_nxt = 1'b1; phase_nxt = PH_STOP4; end
        PH_WR_BIT: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          scl_nxt     = 1'b1;
          phase_nxt   = PH_WR_LOW;
        end
        PH_WR_LOW: begin
          scl_nxt = 1'b0;
          if (bit_cnt_r[3]) begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_WR_ACK;
          end else begin
            sda_nxt   = ~shift_r[7];
            phase_nxt = PH_WR_BIT;
          end
        end
        PH_WR_ACK: begin
          ack_nxt   = ~q_rdata.sda_in;
          scl_nxt   = 1'b1;
          phase_nxt = PH_WR_END;
        end
        PH_RD_BIT: begin
          shift_nxt   = {shift_r[6:0], q_rdata.sda_in};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          scl_nxt     = 1'b1;
          phase_nxt   = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          scl_nxt = 1'b0;
          if (bit_cnt_r[3]) begin
            sda_nxt   = ~nack_r;
            phase_nxt = PH_RD_ACK;
          end else begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_RD_BIT;
          end
        end
        PH_RD_ACK: begin scl_nxt = 1'b1; phase_nxt = PH_RD_END; end
        PH_RD_END: begin
          rd_hold_nxt = shift_r;
          sda_nxt     = 1'b1;
          phase_nxt   = PH_IDLE;
          done_nxt    = 1'b1;
        end
        PH_WR_END: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      endcase
    end
  end

  // Hold the result while stalled, drop it once taken.
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      timer_r     <= '0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      ack_r       <= 1'b0;
      nack_r      <= 1'b0;
      rd_hold_r   <= '0;
      ticks_r     <= PHASE_TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      if (fire) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        timer_r   <= timer_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        ack_r     <= ack_nxt;
        nack_r    <= nack_nxt;
        rd_hold_r <= rd_hold_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.scl_drive_low <= scl_nxt;
      out_data_r.sda_drive_low <= sda_nxt;
      out_data_r.busy_res      <= (phase_nxt != PH_IDLE);
      out_data_r.done_res      <= done_nxt;
      out_data_r.read_data     <= rd_hold_nxt;
      out_data_r.ack_ok        <= ack_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one input transfer per bus tick, one result transfer per input.
// Each input is registered in the queue, then in the sequencer's result register.
// Throughput: 1 tick per cycle while out_stall is low; a tick steps all phase state.
// The decode queue of QUEUE_DEPTH entries absorbs output stalls before in_stall rises.
// Reset (rst_n low, synchronous): idle, SCL and SDA released, phase_ticks 100, queue empty.
// Depends on ibe_pkg, ibe_front, ibe_queue, ibe_back and assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_byte_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ibe_pkg::TICK_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ibe_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ibe_pkg::out_item_t         out_data
);
  import ibe_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  ibe_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ibe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  ibe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_CLK(a_done_not_busy, out_valid && out_data.done_res |-> !out_data.busy_res, "done with busy set")
  `ASSERT_CLK(a_no_pop_on_stall, out_valid && out_stall |-> !q_pop, "sequencer stepped while result stalled")
  `ASSERT_ALWAYS(a_pop_needs_entry, q_pop |-> q_valid, "pop from empty queue")

endmodule

### test/i2c_master_byte_engine_checker.sv
`timescale 1ns / 100ps
// Bus-tick checker for the I2C master byte engine: predicts every result transfer
// from the accepted input transfers and the phase length register. Depends on ibe_pkg.
module i2c_master_byte_engine_checker
  import ibe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  output int                fail_count,
  output int                expected_left
);

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_START1, SEQ_START2, SEQ_START3, SEQ_START4,
    SEQ_STOP1, SEQ_STOP2, SEQ_STOP3, SEQ_STOP4,
    SEQ_WR_BIT, SEQ_WR_LOW, SEQ_WR_ACK, SEQ_WR_END,
    SEQ_RD_BIT, SEQ_RD_LOW, SEQ_RD_ACK, SEQ_RD_END
  } seq_t;

  logic [TICK_W-1:0] tick_len;
  seq_t              seq;
  logic [3:0]        bits_done;
  logic [7:0]        shreg;
  logic [TICK_W-1:0] timer;
  logic              scl_low;
  logic              sda_low;
  logic              ack_seen;
  logic              nack_sel;
  logic [7:0]        read_hold;
  out_item_t         bus_q[$];

  // A zero phase length behaves as one tick.
  function automatic void enter(seq_t p);
    seq = p;
    timer = (tick_len == '0) ? '0 : tick_len - 1'b1;
  endfunction

  // End the current phase; return 1 when the sequence completes.
  function automatic logic step_phase(logic sda);
    logic done;
    done = 1'b0;
    case (seq)
      SEQ_START1: begin scl_low = 1'b0; enter(SEQ_START2); end
      SEQ_START2: begin sda_low = 1'b1; enter(SEQ_START3); end
      SEQ_START3: begin scl_low = 1'b1; enter(SEQ_START4); end
      SEQ_STOP1:  begin scl_low = 1'b0; enter(SEQ_STOP2); end
      SEQ_STOP2:  begin sda_low = 1'b0; enter(SEQ_STOP3); end
      SEQ_STOP3:  begin scl_low = 1'b1; enter(SEQ_STOP4); end
      SEQ_WR_BIT: begin
        shreg = shreg << 1;
        bits_done = bits_done + 1'b1;
        scl_low = 1'b1;
        enter(SEQ_WR_LOW);
      end
      SEQ_WR_LOW: begin
        scl_low = 1'b0;
        if (bits_done >= 4'd8) begin
          sda_low = 1'b0;
          enter(SEQ_WR_ACK);
        end else begin
          sda_low = !shreg[7];
          enter(SEQ_WR_BIT);
        end
      end
      SEQ_WR_ACK: begin
        ack_seen = (sda == 1'b0);
        scl_low = 1'b1;
        enter(SEQ_WR_END);
      end
      SEQ_RD_BIT: begin
        shreg = {shreg[6:0], sda};
        bits_done = bits_done + 1'b1;
        scl_low = 1'b1;
        enter(SEQ_RD_LOW);
      end
      SEQ_RD_LOW: begin
        scl_low = 1'b0;
        if (bits_done >= 4'd8) begin
          sda_low = !nack_sel;
          enter(SEQ_RD_ACK);
        end else begin
          sda_low = 1'b0;
          enter(SEQ_RD_BIT);
        end
      end
      SEQ_RD_ACK: begin scl_low = 1'b1; enter(SEQ_RD_END); end
      SEQ_RD_END: begin
        read_hold = shreg;
        sda_low = 1'b1;
        seq = SEQ_IDLE;
        done = 1'b1;
      end
      SEQ_WR_END: begin
        sda_low = 1'b1;
        seq = SEQ_IDLE;
        done = 1'b1;
      end
      default: begin
        seq = SEQ_IDLE;
        done = 1'b1;
      end
    endcase
    return done;
  endfunction

  function automatic out_item_t bus_tick(in_item_t it);
    out_item_t r;
    logic      done;
    done = 1'b0;
    if (seq == SEQ_IDLE) begin
      if (it.cmd_valid) begin
        bits_done = '0;
        case (it.command)
          CMD_START: begin
            sda_low = 1'b0;
            enter(SEQ_START1);
          end
          CMD_STOP: begin
            sda_low = 1'b1;
            enter(SEQ_STOP1);
          end
          CMD_WRITE: begin
            shreg = it.write_byte;
            sda_low = !it.write_byte[7];
            scl_low = 1'b0;
            enter(SEQ_WR_BIT);
          end
          default: begin
            shreg = '0;
            nack_sel = it.send_nack;
            sda_low = 1'b0;
            scl_low = 1'b0;
            enter(SEQ_RD_BIT);
          end
        endcase
      end
    end else if (timer != '0) begin
      timer = timer - 1'b1;
    end else begin
      done = step_phase(it.sda_in);
    end
    r.scl_drive_low = scl_low;
    r.sda_drive_low = sda_low;
    r.busy_res      = (seq != SEQ_IDLE);
    r.done_res      = done;
    r.read_data     = read_hold;
    r.ack_ok        = ack_seen;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 50)
        $display("%0t checker: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tick_len  = PHASE_TICKS_RESET;
      seq       = SEQ_IDLE;
      bits_done = '0;
      shreg     = '0;
      timer     = '0;
      scl_low   = 1'b0;
      sda_low   = 1'b0;
      ack_seen  = 1'b0;
      nack_sel  = 1'b0;
      read_hold = '0;
      bus_q.delete();
    end else begin
      if (cfg_we)
        tick_len = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (bus_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t checker: result with nothing pending, actual %h", $time, out_data);
        end else begin
          want = bus_q.pop_front();
          check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(out_data.scl_drive_low));
          check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(out_data.sda_drive_low));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("ack_ok", 8'(want.ack_ok), 8'(out_data.ack_ok));
        end
      end
      if (in_valid && !in_stall)
        bus_q.push_back(bus_tick(in_data));
    end
    expected_left <= bus_q.size();
  end

endmodule

### test/i2c_master_byte_engine_tb.sv
`timescale 1ns / 100ps
// Top of the I2C master byte engine testbench: clock, reset, bus-tick stimulus and verdict.
// Depends on ibe_pkg, i2c_master_byte_engine and i2c_master_byte_engine_checker.
module i2c_master_byte_engine_tb;
  import ibe_pkg::*;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [TICK_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;

  int fail_count;
  int expected_left;
  int ticks_sent = 0;
  int out_xfers  = 0;
  int done_cnt   = 0;
  bit last_busy  = 1'b0;
  bit quiet      = 1'b0;

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  i2c_master_byte_engine_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Track completions and the last busy flag so commands land on an idle engine.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      out_xfers <= out_xfers + 1;
      last_busy <= out_data.busy_res;
      if (out_data.done_res)
        done_cnt <= done_cnt + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the engine up.
  initial begin
    int  hold_cnt;
    bit  held;
    hold_cnt = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && out_xfers >= 300) begin
        held = 1'b1;
        hold_cnt = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 12);
      end
    end
  end

  function automatic in_item_t cmd_item(logic [1:0] cmd, logic [7:0] data, logic nack);
    in_item_t it;
    it.cmd_valid  = 1'b1;
    it.command    = cmd;
    it.write_byte = data;
    it.send_nack  = nack;
    it.sda_in     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t any_cmd();
    return cmd_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t idle_item();
    in_item_t it;
    it = any_cmd();
    it.cmd_valid = 1'b0;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  // Hold off register writes until the sequencer has gone idle.
  task automatic set_ticks(logic [TICK_W-1:0] value);
    drain();
    while (last_busy) begin
      send_item(idle_item());
      drain();
    end
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one command, then tick until a completion shows up; noise_pct of the
  // ticks in between carry a stray command that a busy engine must drop.
  task automatic run_command(logic [1:0] cmd, logic [7:0] data, logic nack, int noise_pct);
    int seen;
    seen = done_cnt;
    send_item(cmd_item(cmd, data, nack));
    while (done_cnt == seen)
      send_item(($urandom_range(0, 99) < noise_pct) ? any_cmd() : idle_item());
  endtask

  task automatic flood(int n);
    repeat (n) send_item(any_cmd());
  endtask

  initial begin
    int round_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset phase length: one start sequence.
    run_command(CMD_START, 8'h00, 1'b0, 0);

    // Short phase length, back-to-back commands with no idling on either side.
    quiet <= 1'b1;
    set_ticks(16'd2);
    flood(150);
    quiet <= 1'b0;

    // Zero phase length, byte extremes, ack and nack, then back-to-back commands.
    set_ticks('0);
    run_command(CMD_START, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 0);
    run_command(CMD_READ, 8'h00, 1'b0, 0);
    run_command(CMD_READ, 8'hFF, 1'b1, 0);
    run_command(CMD_STOP, 8'h00, 1'b0, 0);
    flood(60);

    for (int r = 0; r < 3; r++) begin
      set_ticks((r == 0) ? 16'd1 : 16'($urandom_range(0, 2)));
      round_end = ticks_sent + 150;
      while (ticks_sent < round_end) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1))
            flood($urandom_range(1, 20));
          else
            run_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 30);
        end else begin
          run_command(CMD_START, 8'h00, 1'b0, 3);
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
              run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 3);
            else
              run_command(CMD_READ, 8'h00, 1'($urandom_range(0, 1)), 3);
          end
          run_command(CMD_STOP, 8'h00, 1'b0, 3);
        end
        repeat ($urandom_range(0, 3)) send_item(idle_item());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
